/* hw/rtl/sbe_message_validator_macros.svh */
// assertion macros shared by the message validator rtl
// depends on clk and arst_n being visible at the point of use
`ifndef SBE_MESSAGE_VALIDATOR_MACROS_SVH
`define SBE_MESSAGE_VALIDATOR_MACROS_SVH
// implication or plain property, sampled on clk, off during reset
`define SBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen
`define SBE_NEVER(lbl, cond, msg) \
	`SBE_ASSERT(lbl, !(cond), msg)
`endif

/* hw/rtl/sbe_pkg.sv */
// package for the message validator: status codes, opcodes, fsm states
// and the table write/read structs; no dependencies
package sbe_pkg;
	localparam int HDR_BYTES = 8;
	localparam int GHDR_BYTES = 4;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TMPL = 2'd1;
	localparam logic [1:0] OP_GLEN = 2'd2;

	localparam logic CFG_MAX_MSG = 1'b0;
	localparam logic CFG_MAX_ENT = 1'b1;

	localparam logic [3:0] STAT_OK        = 4'd0;
	localparam logic [3:0] STAT_TOO_LARGE = 4'd1;
	localparam logic [3:0] STAT_SHORT_HDR = 4'd2;
	localparam logic [3:0] STAT_UNKNOWN   = 4'd3;
	localparam logic [3:0] STAT_ROOT_SHORT = 4'd4;
	localparam logic [3:0] STAT_ROOT_TRUNC = 4'd5;
	localparam logic [3:0] STAT_GHDR_TRUNC = 4'd6;
	localparam logic [3:0] STAT_GBLK_SHORT = 4'd7;
	localparam logic [3:0] STAT_ZERO_SIZE = 4'd8;
	localparam logic [3:0] STAT_G_OVERFLOW = 4'd9;
	localparam logic [3:0] STAT_TOO_MANY  = 4'd10;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_HFETCH, S_SCAN_RD, S_SCAN_CMP, S_ROOT,
		S_GRP, S_GFETCH, S_GCHK, S_GMUL, S_DONE
	} state_t;

	typedef struct packed {
		logic        tmpl_we;
		logic        grp_we;
		logic [3:0]  slot;
		logic [15:0] key;
		logic [15:0] len;
		logic [3:0]  total;
		logic [2:0]  gidx;
		logic        live;
	} tbl_wr_t;

	typedef struct packed {
		logic        live;
		logic [15:0] id;
		logic [15:0] root;
		logic [5:0]  total;
		logic [15:0] glen;
	} tbl_rd_t;
endpackage

/* hw/rtl/sbe_message_validator.sv */
// throughput: a byte a cycle while idle; after the last byte the check runs
// with ready low meanwhile. each repeating group uses one shared 16x16
// multiplier and a 4-byte fetch from the message buffer.
// reset: table live and group valid bits cleared, limits 4096 and 1024.
// uses sbe_pkg, sbe_tbl and the assertion macro header
`include "sbe_message_validator_macros.svh"
module sbe_message_validator #(
	parameter int MAX_BYTES = 4096,
	parameter int TEMPLATES = 16,
	parameter int MAX_GROUPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte[7:0] slot[11:8] template_key[27:12] length_value[43:28]
	// group_total[47:44] group_index[50:48] entry_valid[51] zero[55:52]
	input  logic [55:0] s_tdata,
	input  logic        s_tlast,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[3:0] header_template[19:4] message_length[35:20] body_end[51:36]
	// zero[55:52]
	output logic [55:0] m_tdata
);
	import sbe_pkg::*;

	localparam int AW = $clog2(MAX_BYTES);
	localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
	localparam int MG = (MAX_GROUPS > 0) ? MAX_GROUPS : 1;
	localparam int CW = (TEMPLATES * MG > 1) ? $clog2(TEMPLATES * MG) : 1;

	state_t state_q, state_d;
	logic [7:0]  buf_mem [MAX_BYTES];
	logic [7:0]  buf_rd_q;
	logic [AW-1:0] rd_addr;
	logic [12:0] max_msg_q;
	logic [15:0] max_ent_q;
	logic [15:0] cnt_q, size_q, tmpl_q, end_q;
	logic [3:0]  stat_q;
	logic [17:0] pos_q;
	logic [2:0]  fk_q;
	logic [31:0] word_q, prod_q;
	logic [TW:0] scan_q;
	logic [5:0]  g_q, groups_q;
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic        acc;
	logic [16:0] lim;
	logic [17:0] root_end, remaining;
	tbl_wr_t     twr;
	tbl_rd_t     trd;

	assign s_tready = (state_q == S_IDLE);
	assign acc = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign lim = (17'(max_msg_q) < 17'(MAX_BYTES)) ? 17'(max_msg_q) : 17'(MAX_BYTES);
	assign root_end = 18'(HDR_BYTES) + 18'(word_q[15:0]);
	assign remaining = 18'(size_q) - pos_q;
	assign rd_addr = AW'(pos_q + 18'(fk_q));

	always_comb begin
		twr.tmpl_we = acc && (s_tuser == OP_TMPL);
		twr.grp_we = acc && (s_tuser == OP_GLEN);
		twr.slot = s_tdata[11:8];
		twr.key = s_tdata[27:12];
		twr.len = s_tdata[43:28];
		twr.total = s_tdata[47:44];
		twr.gidx = s_tdata[50:48];
		twr.live = s_tdata[51];
	end

	sbe_tbl #(.TEMPLATES(TEMPLATES), .MAX_GROUPS(MAX_GROUPS)) u_tbl (
		.clk(clk),
		.arst_n(arst_n),
		.wr(twr),
		.rd_slot(scan_q[TW-1:0]),
		.rd_cell(CW'(32'(scan_q) * MG + 32'(g_q))),
		.rd(trd)
	);

	// message buffer, written while idle, read during the check
	always_ff @(posedge clk) begin
		if (acc && (s_tuser == OP_BYTE) && (32'(cnt_q) < MAX_BYTES)) begin
			buf_mem[cnt_q[AW-1:0]] <= s_tdata[7:0];
		end
		buf_rd_q <= buf_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc && (s_tuser == OP_BYTE) && s_tlast) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (17'(size_q) > lim || size_q < 16'(HDR_BYTES)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_HFETCH;
				end
			end
			S_HFETCH: begin
				if (fk_q == 3'd4) begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = (32'(scan_q) == TEMPLATES) ? S_DONE : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				state_d = (trd.live && trd.id == word_q[31:16]) ? S_ROOT : S_SCAN_RD;
			end
			S_ROOT: begin
				if (word_q[15:0] < trd.root || 18'(size_q) < root_end) begin
					state_d = S_DONE;
				end else begin
					state_d = S_GRP;
				end
			end
			S_GRP: begin
				if (g_q == groups_q || 18'(size_q) < pos_q + 18'(GHDR_BYTES)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_GFETCH;
				end
			end
			S_GFETCH: begin
				if (fk_q == 3'd4) begin
					state_d = S_GCHK;
				end
			end
			S_GCHK: begin
				if (word_q[15:0] < trd.glen || (word_q[31:16] != 16'd0 && word_q[15:0] == 16'd0)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_GMUL;
				end
			end
			S_GMUL: begin
				if (18'(prod_q) > remaining || prod_q[31:18] != '0 ||
						word_q[31:16] > max_ent_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_GRP;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_q <= 13'd4096;
			max_ent_q <= 16'd1024;
			cnt_q <= '0;
			size_q <= '0;
			tmpl_q <= '0;
			end_q <= '0;
			stat_q <= STAT_OK;
			pos_q <= '0;
			fk_q <= '0;
			word_q <= '0;
			prod_q <= '0;
			scan_q <= '0;
			g_q <= '0;
			groups_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_MSG) begin
					max_msg_q <= cfg_data[12:0];
				end else begin
					max_ent_q <= cfg_data;
				end
			end
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q <= {4'd0, end_q, size_q, tmpl_q, stat_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc && (s_tuser == OP_BYTE)) begin
						if (s_tlast) begin
							size_q <= (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
							cnt_q <= '0;
						end else if (cnt_q != 16'hFFFF) begin
							cnt_q <= cnt_q + 16'd1;
						end
					end
				end
				S_CHECK: begin
					tmpl_q <= '0;
					end_q <= '0;
					pos_q <= '0;
					fk_q <= '0;
					scan_q <= '0;
					g_q <= '0;
					if (17'(size_q) > lim) begin
						stat_q <= STAT_TOO_LARGE;
					end else if (size_q < 16'(HDR_BYTES)) begin
						stat_q <= STAT_SHORT_HDR;
					end
				end
				S_HFETCH, S_GFETCH: begin
					// read data comes back in the cycle after its address is issued,
					// bytes shift in from the top so byte 0 ends lowest
					if (fk_q != 3'd0) begin
						word_q <= {buf_rd_q, word_q[31:8]};
					end
					fk_q <= (fk_q == 3'd4) ? 3'd0 : fk_q + 3'd1;
				end
				S_SCAN_RD: begin
					tmpl_q <= word_q[31:16];
					if (32'(scan_q) == TEMPLATES) begin
						stat_q <= STAT_UNKNOWN;
					end
				end
				S_SCAN_CMP: begin
					if (!(trd.live && trd.id == word_q[31:16])) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ROOT: begin
					pos_q <= root_end;
					groups_q <= trd.total;
					if (word_q[15:0] < trd.root) begin
						stat_q <= STAT_ROOT_SHORT;
					end else if (18'(size_q) < root_end) begin
						stat_q <= STAT_ROOT_TRUNC;
					end
				end
				S_GRP: begin
					if (g_q == groups_q) begin
						stat_q <= STAT_OK;
						end_q <= pos_q[15:0];
					end else if (18'(size_q) < pos_q + 18'(GHDR_BYTES)) begin
						stat_q <= STAT_GHDR_TRUNC;
					end
				end
				S_GCHK: begin
					pos_q <= pos_q + 18'(GHDR_BYTES);
					prod_q <= 32'(word_q[31:16]) * 32'(word_q[15:0]);
					if (word_q[15:0] < trd.glen) begin
						stat_q <= STAT_GBLK_SHORT;
					end else if (word_q[31:16] != 16'd0 && word_q[15:0] == 16'd0) begin
						stat_q <= STAT_ZERO_SIZE;
					end
				end
				S_GMUL: begin
					if (18'(prod_q) > remaining || prod_q[31:18] != '0) begin
						stat_q <= STAT_G_OVERFLOW;
					end else if (word_q[31:16] > max_ent_q) begin
						stat_q <= STAT_TOO_MANY;
					end else begin
						pos_q <= pos_q + 18'(prod_q);
						g_q <= g_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	`SBE_ASSERT(a_ok_end, (m_tvalid && m_tdata[3:0] == STAT_OK) |-> m_tdata[51:36] >= 16'(HDR_BYTES), "ok word with body end inside header")
	`SBE_ASSERT(a_fail_end, (m_tvalid && m_tdata[3:0] != STAT_OK) |-> m_tdata[51:36] == 16'd0, "failed word with nonzero body end")
	`SBE_ASSERT(a_nohdr_tmpl, (m_tvalid && (m_tdata[3:0] == STAT_TOO_LARGE || m_tdata[3:0] == STAT_SHORT_HDR)) |-> m_tdata[19:4] == 16'd0, "template id without header")
	`SBE_ASSERT(a_word_src, (m_tvalid_q && !$past(m_tvalid_q)) |-> $past(state_q) == S_DONE, "result word outside done state")
endmodule

/* hw/rtl/sbe_tbl.sv */
// template table: ids, root lengths, group totals, live bits and group
// block lengths, with registered reads; uses sbe_pkg
module sbe_tbl #(
	parameter int TEMPLATES = 16,
	parameter int MAX_GROUPS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbe_pkg::tbl_wr_t wr,
	input  logic [((TEMPLATES > 1) ? $clog2(TEMPLATES) : 1)-1:0] rd_slot,
	input  logic [((TEMPLATES * ((MAX_GROUPS > 0) ? MAX_GROUPS : 1) > 1) ?
		$clog2(TEMPLATES * ((MAX_GROUPS > 0) ? MAX_GROUPS : 1)) : 1)-1:0] rd_cell,
	output sbe_pkg::tbl_rd_t rd
);
	import sbe_pkg::*;

	localparam int TW = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
	localparam int MG = (MAX_GROUPS > 0) ? MAX_GROUPS : 1;
	localparam int CELLS = TEMPLATES * MG;
	localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [15:0] id_mem [TEMPLATES];
	logic [15:0] root_mem [TEMPLATES];
	logic [5:0]  tot_mem [TEMPLATES];
	logic [15:0] glen_mem [CELLS];
	logic [TEMPLATES-1:0] live_q;
	logic [CELLS-1:0]     gvalid_q;
	logic        slot_ok, cell_ok;
	logic [TW+3:0] slot_w;
	logic [CW-1:0] wr_cell;
	logic [5:0]  total_sat;
	logic        live_s1, gvalid_s1;
	logic [15:0] id_s1, root_s1, glen_s1;
	logic [5:0]  tot_s1;

	always_comb begin
		slot_w = (TW + 4)'(wr.slot);
		slot_ok = 32'(wr.slot) < TEMPLATES;
		cell_ok = slot_ok && (32'(wr.gidx) < MAX_GROUPS);
		wr_cell = CW'(32'(wr.slot) * MG + 32'(wr.gidx));
		total_sat = (32'(wr.total) > MAX_GROUPS) ? 6'(MAX_GROUPS) : 6'(wr.total);
	end

	always_ff @(posedge clk) begin
		if (wr.tmpl_we && slot_ok) begin
			id_mem[slot_w[TW-1:0]] <= wr.key;
			root_mem[slot_w[TW-1:0]] <= wr.len;
			tot_mem[slot_w[TW-1:0]] <= total_sat;
		end
		if (wr.grp_we && cell_ok) begin
			glen_mem[wr_cell] <= wr.len;
		end
		id_s1 <= id_mem[rd_slot];
		root_s1 <= root_mem[rd_slot];
		tot_s1 <= tot_mem[rd_slot];
		glen_s1 <= glen_mem[rd_cell];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			gvalid_q <= '0;
			live_s1 <= 1'b0;
			gvalid_s1 <= 1'b0;
		end else begin
			if (wr.tmpl_we && slot_ok) begin
				live_q[slot_w[TW-1:0]] <= wr.live;
			end
			if (wr.grp_we && cell_ok) begin
				gvalid_q[wr_cell] <= 1'b1;
			end
			live_s1 <= live_q[rd_slot];
			gvalid_s1 <= gvalid_q[rd_cell];
		end
	end

	// a group cell never written reads as zero
	always_comb begin
		rd.live = live_s1;
		rd.id = id_s1;
		rd.root = root_s1;
		rd.total = tot_s1;
		rd.glen = gvalid_s1 ? glen_s1 : 16'd0;
	end
endmodule
